// ===== rtl/pol_pkg.sv =====
// Shared command, status and shift codes plus the cell-row bus types for the ordered list.
package pol_pkg;

  // command field of an input word
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_LOCATE = 3'd2;
  localparam logic [2:0] CMD_GET    = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // status field of a result word
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADPOS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // shift operation broadcast to every cell
  localparam logic [1:0] SH_HOLD   = 2'd0;
  localparam logic [1:0] SH_INSERT = 2'd1;
  localparam logic [1:0] SH_DELETE = 2'd2;

  localparam int POS_W  = 5;
  localparam int BYTE_W = 8;

  // command broadcast from the controller to the cell row
  typedef struct packed {
    logic [1:0]        shift;     // SH_* code
    logic              scan_get;  // 1: probe matches by position, 0: by value
    logic [POS_W-1:0]  pos;       // 1-based position
    logic [BYTE_W-1:0] value;     // byte to insert or to look for
  } cmd_bus_t;

  // probe word travelling down the row, one cell per cycle
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [BYTE_W-1:0] data;
  } probe_t;

endpackage

// ===== rtl/pol_cell.sv =====
// One list cell: holds one entry, shifts with its neighbors, and checks the passing probe.
module pol_cell
  import pol_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_bus_t            bus,
  input  logic [CW-1:0]       count,
  input  logic [BYTE_W-1:0]   left_data,
  input  logic [BYTE_W-1:0]   right_data,
  output logic [BYTE_W-1:0]   data,
  input  probe_t              probe_in,
  input  logic [CW-1:0]       pidx_in,
  output probe_t              probe_out,
  output logic [CW-1:0]       pidx_out
);

  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [BYTE_W-1:0] data_r, data_nxt;
  probe_t            probe_r, probe_nxt;
  logic [CW-1:0]     pidx_r, pidx_nxt;

  logic [XW-1:0] my_pos, cnt_x, pos_x;
  logic          in_use, match;

  assign my_pos = XW'(IDX + 1);
  assign cnt_x  = XW'(count);
  assign pos_x  = XW'(bus.pos);
  assign in_use = (my_pos <= cnt_x);

  // insert: take the new byte at the target slot, the left entry behind it
  // delete: take the right entry from the target slot on
  always_comb begin
    data_nxt = data_r;
    unique case (bus.shift)
      SH_INSERT: begin
        if (my_pos == pos_x) begin
          data_nxt = bus.value;
        end else if (my_pos > pos_x) begin
          data_nxt = left_data;
        end
      end
      SH_DELETE: begin
        if (my_pos >= pos_x) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  assign match = in_use && (bus.scan_get ? (my_pos == pos_x) : (data_r == bus.value));

  // keep the first hit; a later cell only passes it on
  always_comb begin
    probe_nxt = probe_in;
    pidx_nxt  = pidx_in;
    if (probe_in.vld && !probe_in.hit && match) begin
      probe_nxt.hit  = 1'b1;
      probe_nxt.data = data_r;
      pidx_nxt       = CW'(IDX + 1);
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    pidx_r <= pidx_nxt;
    if (!rst_n) begin
      probe_r <= '0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  assign data      = data_r;
  assign probe_out = probe_r;
  assign pidx_out  = pidx_r;

endmodule

// ===== rtl/positional_ordered_list_core.sv =====
// Top level of the positional ordered list: controller, count and the row of cells.
// Insert, delete, clear and unknown commands pass the execute and hold states before out_tvalid rises.
// Locate and get send a probe down the cell row, one cell per cycle.
// One command is in work at a time; a new word is taken while the last result waits.
// A new command is taken only once the last one has moved its result to the output register.
// rst_n (synchronous, active low) empties the list; cell contents are kept but never read.
module positional_ordered_list_core
  import pol_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // command[2:0], position[7:3], value[15:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status[1:0], found_value[9:2], found_position[14:10],
                                  // length[19:15], is_empty[20], zero[23:21]
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [2:0]        cmd_r;
  logic [POS_W-1:0]  pos_r;
  logic [BYTE_W-1:0] val_r;
  logic [CW-1:0]     count_r, count_nxt;

  // pending result, waiting for the output register
  logic [1:0]        res_status_r, res_status_nxt;
  logic [BYTE_W-1:0] res_fval_r, res_fval_nxt;
  logic [POS_W-1:0]  res_fpos_r, res_fpos_nxt;

  logic              out_vld_r;
  logic [23:0]       out_data_r;

  logic              in_fire, out_free;
  logic [XW-1:0]     pos_x, cnt_x;
  logic              pos_zero, ins_pos_ok, acc_pos_ok, list_full, launch;
  cmd_bus_t          bus;

  // cell row wiring
  logic [BYTE_W-1:0] data_w [DEPTH];
  probe_t            probe_w [DEPTH+1];
  logic [CW-1:0]     pidx_w [DEPTH+1];
  probe_t            tail;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  // position checks against the current length
  assign pos_x      = XW'(pos_r);
  assign cnt_x      = XW'(count_r);
  assign pos_zero   = (pos_r == '0);
  assign ins_pos_ok = !pos_zero && (pos_x <= cnt_x + XW'(1));
  assign acc_pos_ok = !pos_zero && (pos_x <= cnt_x);
  assign list_full  = (cnt_x == XW'(DEPTH));

  assign launch = (state_r == S_EXEC) && ((cmd_r == CMD_LOCATE) || (cmd_r == CMD_GET));

  // broadcast the shift only in the execute cycle; hold the scan keys throughout
  always_comb begin
    bus.shift    = SH_HOLD;
    bus.scan_get = (cmd_r == CMD_GET);
    bus.pos      = pos_r;
    bus.value    = val_r;
    if (state_r == S_EXEC) begin
      if ((cmd_r == CMD_INSERT) && ins_pos_ok && !list_full) begin
        bus.shift = SH_INSERT;
      end else if ((cmd_r == CMD_DELETE) && acc_pos_ok) begin
        bus.shift = SH_DELETE;
      end
    end
  end

  // inject the probe at the head of the row
  assign probe_w[0] = '{vld: launch, hit: 1'b0, data: '0};
  assign pidx_w[0]  = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [BYTE_W-1:0] left_d, right_d;
    if (k == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_left
      assign left_d = data_w[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign right_d = data_w[k];
    end else begin : g_right
      assign right_d = data_w[k+1];
    end
    pol_cell #(
      .IDX (k),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .bus        (bus),
      .count      (count_r),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (data_w[k]),
      .probe_in   (probe_w[k]),
      .pidx_in    (pidx_w[k]),
      .probe_out  (probe_w[k+1]),
      .pidx_out   (pidx_w[k+1])
    );
  end

  assign tail = probe_w[DEPTH];

  // sequencer, count update and result capture
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_fval_nxt   = res_fval_r;
    res_fpos_nxt   = res_fpos_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_nxt = ST_OK;
        res_fval_nxt   = '0;
        res_fpos_nxt   = '0;
        state_nxt      = S_HOLD;
        if (launch) begin
          state_nxt = S_SCAN;
        end
        if (cmd_r == CMD_INSERT) begin
          if (!ins_pos_ok) begin
            res_status_nxt = ST_BADPOS;
          end else if (list_full) begin
            res_status_nxt = ST_FULL;
          end
        end
        if ((cmd_r == CMD_DELETE) && !acc_pos_ok) begin
          res_status_nxt = ST_BADPOS;
        end
        if (bus.shift == SH_INSERT) begin
          count_nxt = count_r + CW'(1);
        end else if (bus.shift == SH_DELETE) begin
          count_nxt = count_r - CW'(1);
        end else if (cmd_r == CMD_CLEAR) begin
          count_nxt = '0;
        end
      end
      S_SCAN: begin
        if (tail.vld) begin
          state_nxt = S_HOLD;
          if (bus.scan_get) begin
            res_status_nxt = acc_pos_ok ? ST_OK : ST_BADPOS;
            res_fval_nxt   = tail.hit ? tail.data : '0;
            res_fpos_nxt   = '0;
          end else begin
            res_status_nxt = tail.hit ? ST_OK : ST_NOTFOUND;
            res_fval_nxt   = '0;
            res_fpos_nxt   = tail.hit ? POS_W'(pidx_w[DEPTH]) : '0;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_tdata[2:0];
      pos_r <= in_tdata[7:3];
      val_r <= in_tdata[15:8];
    end
    res_status_r <= res_status_nxt;
    res_fval_r   <= res_fval_nxt;
    res_fpos_r   <= res_fpos_nxt;
    // load the output word when the slot frees
    if ((state_r == S_HOLD) && out_free) begin
      out_data_r <= {3'b000, (count_r == '0), POS_W'(count_r),
                     res_fpos_r, res_fval_r, res_status_r};
    end
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if ((state_r == S_HOLD) && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // the list never grows past its cell row
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(count_r) <= XW'(DEPTH))
    else $error("list length exceeds cell count");

  // a probe reaches the tail only while a scan is running
  a_probe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> (state_r == S_SCAN))
    else $error("probe arrived outside a scan");

  // an accepted insert shift grows the list by exactly one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (bus.shift == SH_INSERT) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the list by one");

  // a new result word appears only out of the hold state
  a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_vld_r ##1 out_vld_r) |-> ($past(state_r) == S_HOLD))
    else $error("result word raised outside the hold state");

endmodule
